FILE: rtl/core/mvm_pkg.sv
package mvm_pkg;

    localparam int MAX_DIM   = 64;
    localparam int FRAC_BITS = 16;

    localparam int DATA_W = 32;
    localparam int ACC_W  = 64;
    localparam int DIM_W  = 7;
    localparam int IDX_W  = 6;
    localparam int ADDR_W = $clog2(MAX_DIM);
    localparam int CNT_W  = $clog2(MAX_DIM + 1);

    localparam logic [1:0] CFG_NUM_ROWS  = 2'd0;
    localparam logic [1:0] CFG_NUM_COLS  = 2'd1;
    localparam logic [1:0] CFG_TRANSPOSE = 2'd2;

    localparam logic KIND_VECTOR = 1'b0;
    localparam logic KIND_MATRIX = 1'b1;

    // zero is used as one, anything above the maximum as the maximum
    function automatic logic [CNT_W-1:0] dim_clamp(input logic [DIM_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0)
        begin
            r = CNT_W'(1);
        end
        else if (int'(v) > MAX_DIM)
        begin
            r = CNT_W'(MAX_DIM);
        end
        else
        begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0]   s;
        logic signed [ACC_W-1:0] r;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
        begin
            r = {s[ACC_W], {(ACC_W-1){~s[ACC_W]}}};
        end
        else
        begin
            r = s[ACC_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_narrow(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0]  hi;
        logic signed [ACC_W-1:0]  lo;
        logic signed [DATA_W-1:0] r;
        hi = ACC_W'({1'b0, {(DATA_W-1){1'b1}}});
        lo = -hi - ACC_W'(1);
        if (a > hi)
        begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (a < lo)
        begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            r = a[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/mvm_ram.sv
module mvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/matrix_vector_multiply_unit.sv
// Q16.16 matrix-vector multiply (M*v, or v*M with transpose_mode set). Load the
// vector first with kind 0 beats, then stream the matrix row-major with kind 1
// beats. A matrix beat passes through the read of the vector and column-sum
// memories, a registered 32x32 multiply, then the saturating 64-bit accumulate
// and write-back; this read-multiply-accumulate sequence on the memories sets
// the rate. In normal mode one result leaves at each row end; in transposed mode
// the column sums are read out after the last matrix beat, each column in use
// through a read state and an output state (num_cols limited to 1..64), during
// which no input is taken. Output back-pressure only stalls a matrix beat that
// produces a result and the column-sum read-out.
// Column sums start cleared through per-entry valid bits, so there is no clearing
// pass after reset. Config writes are taken only while idle; writes to the
// defined indices restart the pass, and the loaded vector is kept.
module matrix_vector_multiply_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   kind,
    input  logic signed [mvm_pkg::DATA_W-1:0]      value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [mvm_pkg::DATA_W-1:0]      result_value,
    output logic [mvm_pkg::IDX_W-1:0]              result_index,
    output logic                                   last,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [1:0]                             cfg_index,
    input  logic [mvm_pkg::DIM_W-1:0]              cfg_data
);

    import mvm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_FLUSH_RD,
        S_FLUSH_OUT
    } state_t;

    state_t state_reg;

    logic [DIM_W-1:0]  num_rows_reg;
    logic [DIM_W-1:0]  num_cols_reg;
    logic              transpose_reg;
    logic [CNT_W-1:0]  vec_cnt_reg;
    logic [ADDR_W-1:0] row_pos_reg;
    logic [ADDR_W-1:0] col_pos_reg;
    logic [ADDR_W-1:0] flush_idx_reg;
    logic [MAX_DIM-1:0] col_valid_reg;
    logic signed [ACC_W-1:0]  row_sum_reg;
    logic signed [ACC_W-1:0]  prod_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] result_value_reg;
    logic [IDX_W-1:0]         result_index_reg;
    logic                     last_reg;

    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] cols;
    logic             col_end;
    logic             row_end;
    logic             flush_end;
    logic             out_free;
    logic             out_load;
    logic             in_beat;
    logic             cfg_beat;

    logic               vec_wr_en;
    logic               vec_rd_en;
    logic [ADDR_W-1:0]  vec_rd_addr;
    logic [DATA_W-1:0]  vec_rd_data;
    logic               cs_wr_en;
    logic               cs_rd_en;
    logic [ADDR_W-1:0]  cs_rd_addr;
    logic [ACC_W-1:0]   cs_rd_data;

    logic signed [ACC_W-1:0] prod_full;
    logic signed [ACC_W-1:0] acc_in;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [ACC_W-1:0] flush_sum;

    assign rows      = dim_clamp(num_rows_reg);
    assign cols      = dim_clamp(num_cols_reg);
    assign col_end   = (CNT_W'(col_pos_reg) + CNT_W'(1)) == cols;
    assign row_end   = (CNT_W'(row_pos_reg) + CNT_W'(1)) == rows;
    assign flush_end = (CNT_W'(flush_idx_reg) + CNT_W'(1)) == cols;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = out_free
                     && (((state_reg == S_ACC) && !transpose_reg && col_end)
                         || (state_reg == S_FLUSH_OUT));

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign in_beat   = in_valid && in_ready;
    assign cfg_beat  = cfg_valid && cfg_ready;

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign result_index = result_index_reg;
    assign last         = last_reg;

    // memory control
    always_comb
    begin
        vec_wr_en   = in_beat && (kind == KIND_VECTOR) && (int'(vec_cnt_reg) < MAX_DIM);
        vec_rd_en   = in_beat && (kind == KIND_MATRIX);
        vec_rd_addr = transpose_reg ? row_pos_reg : col_pos_reg;
        cs_wr_en    = (state_reg == S_ACC) && transpose_reg;
        cs_rd_en    = vec_rd_en || (state_reg == S_FLUSH_RD);
        cs_rd_addr  = (state_reg == S_FLUSH_RD) ? flush_idx_reg : col_pos_reg;
    end

    assign prod_full = ACC_W'(value_reg) * ACC_W'($signed(vec_rd_data));
    assign acc_in    = transpose_reg
                     ? (col_valid_reg[col_pos_reg] ? $signed(cs_rd_data) : '0)
                     : row_sum_reg;
    assign acc_sum   = sat_add(acc_in, prod_reg);
    assign flush_sum = col_valid_reg[flush_idx_reg] ? $signed(cs_rd_data) : '0;

    mvm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_DIM)
    ) u_vec_ram (
        .clk     (clk),
        .wr_en   (vec_wr_en),
        .wr_addr (vec_cnt_reg[ADDR_W-1:0]),
        .wr_data (value),
        .rd_en   (vec_rd_en),
        .rd_addr (vec_rd_addr),
        .rd_data (vec_rd_data)
    );

    mvm_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_DIM)
    ) u_colsum_ram (
        .clk     (clk),
        .wr_en   (cs_wr_en),
        .wr_addr (col_pos_reg),
        .wr_data (acc_sum),
        .rd_en   (cs_rd_en),
        .rd_addr (cs_rd_addr),
        .rd_data (cs_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            num_rows_reg  <= DIM_W'(MAX_DIM);
            num_cols_reg  <= DIM_W'(MAX_DIM);
            transpose_reg <= 1'b0;
            vec_cnt_reg   <= '0;
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            flush_idx_reg <= '0;
            col_valid_reg <= '0;
            row_sum_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_beat && (cfg_index == CFG_NUM_ROWS || cfg_index == CFG_NUM_COLS
                                     || cfg_index == CFG_TRANSPOSE))
                    begin
                        if (cfg_index == CFG_NUM_ROWS)
                        begin
                            num_rows_reg <= cfg_data;
                        end
                        else if (cfg_index == CFG_NUM_COLS)
                        begin
                            num_cols_reg <= cfg_data;
                        end
                        else
                        begin
                            transpose_reg <= cfg_data[0];
                        end
                        // restart the pass, keep the vector
                        row_pos_reg   <= '0;
                        col_pos_reg   <= '0;
                        row_sum_reg   <= '0;
                        col_valid_reg <= '0;
                    end
                    if (in_beat)
                    begin
                        value_reg <= value;
                        if (kind == KIND_MATRIX)
                        begin
                            state_reg <= S_MUL;
                        end
                        else if (vec_wr_en)
                        begin
                            vec_cnt_reg <= vec_cnt_reg + CNT_W'(1);
                        end
                    end
                end

                S_MUL:
                begin
                    prod_reg  <= prod_full >>> FRAC_BITS;
                    state_reg <= S_ACC;
                end

                S_ACC:
                begin
                    if (!transpose_reg)
                    begin
                        if (!col_end)
                        begin
                            row_sum_reg <= acc_sum;
                            col_pos_reg <= col_pos_reg + ADDR_W'(1);
                            state_reg   <= S_IDLE;
                        end
                        else if (out_free)
                        begin
                            result_value_reg <= sat_narrow(acc_sum);
                            result_index_reg <= IDX_W'(row_pos_reg);
                            last_reg         <= row_end;
                            row_sum_reg      <= '0;
                            col_pos_reg      <= '0;
                            if (row_end)
                            begin
                                row_pos_reg <= '0;
                                vec_cnt_reg <= '0;
                            end
                            else
                            begin
                                row_pos_reg <= row_pos_reg + ADDR_W'(1);
                            end
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        col_valid_reg[col_pos_reg] <= 1'b1;
                        if (!col_end)
                        begin
                            col_pos_reg <= col_pos_reg + ADDR_W'(1);
                            state_reg   <= S_IDLE;
                        end
                        else
                        begin
                            col_pos_reg <= '0;
                            if (row_end)
                            begin
                                row_pos_reg   <= '0;
                                vec_cnt_reg   <= '0;
                                flush_idx_reg <= '0;
                                state_reg     <= S_FLUSH_RD;
                            end
                            else
                            begin
                                row_pos_reg <= row_pos_reg + ADDR_W'(1);
                                state_reg   <= S_IDLE;
                            end
                        end
                    end
                end

                S_FLUSH_RD:
                begin
                    state_reg <= S_FLUSH_OUT;
                end

                S_FLUSH_OUT:
                begin
                    if (out_free)
                    begin
                        result_value_reg <= sat_narrow(flush_sum);
                        result_index_reg <= IDX_W'(flush_idx_reg);
                        last_reg         <= flush_end;
                        if (flush_end)
                        begin
                            col_valid_reg <= '0;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            flush_idx_reg <= flush_idx_reg + ADDR_W'(1);
                            state_reg     <= S_FLUSH_RD;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: tb/tb_matrix_vector_multiply_unit.sv
`timescale 1ns / 100ps

module tb_matrix_vector_multiply_unit;

    localparam int          SETTLE_CYCLES  = 8;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [1:0]  CFG_UNUSED     = 2'd3;

    typedef logic signed [mvm_pkg::ACC_W-1:0]  acc_t;
    typedef logic signed [mvm_pkg::DATA_W-1:0] elem_t;
    typedef logic [mvm_pkg::DIM_W-1:0]         dim_t;

    typedef struct {
        elem_t                      value;
        logic [mvm_pkg::IDX_W-1:0]  index;
        logic                       last;
    } gemv_elem_t;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    logic                           kind      = mvm_pkg::KIND_VECTOR;
    elem_t                          value     = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    elem_t                          result_value;
    logic [mvm_pkg::IDX_W-1:0]      result_index;
    logic                           last;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [1:0]                     cfg_index = mvm_pkg::CFG_NUM_ROWS;
    logic [mvm_pkg::DIM_W-1:0]      cfg_data  = '0;

    // predictor state
    elem_t                          vec_mem [mvm_pkg::MAX_DIM];
    bit                             vec_loaded [mvm_pkg::MAX_DIM];
    acc_t                           col_acc [mvm_pkg::MAX_DIM];
    acc_t                           row_acc    = '0;
    int                             vec_fill   = 0;
    int                             row_pos    = 0;
    int                             col_pos    = 0;
    logic [mvm_pkg::DIM_W-1:0]      reg_rows   = 7'd64;
    logic [mvm_pkg::DIM_W-1:0]      reg_cols   = 7'd64;
    logic                           reg_tmode  = 1'b0;

    gemv_elem_t                     gemv_results_due [$];
    gemv_elem_t                     head_elem;
    int                             mismatches   = 0;
    int                             items_taken  = 0;
    int                             results_seen = 0;
    int                             idle_cycles  = 0;
    bit                             steady_flow  = 1'b0;

    matrix_vector_multiply_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .result_index (result_index),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int clamp_dim(input logic [mvm_pkg::DIM_W-1:0] d);
        if (d == '0)
        begin
            return 1;
        end
        if (int'(d) > mvm_pkg::MAX_DIM)
        begin
            return mvm_pkg::MAX_DIM;
        end
        return int'(d);
    endfunction

    // q16.16 product, floor toward minus infinity
    function automatic acc_t fixed_mul(input elem_t a, input elem_t b);
        acc_t p;
        p = acc_t'(a) * acc_t'(b);
        return p >>> mvm_pkg::FRAC_BITS;
    endfunction

    function automatic acc_t acc_add_sat(input acc_t a, input acc_t b);
        acc_t s;
        s = a + b;
        if (a[mvm_pkg::ACC_W-1] == b[mvm_pkg::ACC_W-1] &&
            s[mvm_pkg::ACC_W-1] != a[mvm_pkg::ACC_W-1])
        begin
            s = a[mvm_pkg::ACC_W-1] ? {1'b1, {(mvm_pkg::ACC_W-1){1'b0}}}
                                    : {1'b0, {(mvm_pkg::ACC_W-1){1'b1}}};
        end
        return s;
    endfunction

    function automatic elem_t acc_to_elem(input acc_t a);
        if (a > acc_t'(64'sd2147483647))
        begin
            return 32'h7fff_ffff;
        end
        if (a < acc_t'(-64'sd2147483648))
        begin
            return 32'h8000_0000;
        end
        return a[mvm_pkg::DATA_W-1:0];
    endfunction

    function automatic void gemv_clear_pass();
        foreach (col_acc[i])
        begin
            col_acc[i] = '0;
        end
        row_acc = '0;
        row_pos = 0;
        col_pos = 0;
    endfunction

    function automatic void gemv_apply_cfg(input logic [1:0] idx,
                                           input logic [mvm_pkg::DIM_W-1:0] d);
        case (idx)
            mvm_pkg::CFG_NUM_ROWS:  reg_rows  = d;
            mvm_pkg::CFG_NUM_COLS:  reg_cols  = d;
            mvm_pkg::CFG_TRANSPOSE: reg_tmode = d[0];
            default:                return;
        endcase
        gemv_clear_pass();
    endfunction

    // vector entry that the next matrix beat would read
    function automatic int gemv_read_index();
        int rows;
        int cols;
        rows = clamp_dim(reg_rows);
        cols = clamp_dim(reg_cols);
        if (row_pos >= rows || col_pos >= cols)
        begin
            return 0;
        end
        return reg_tmode ? row_pos : col_pos;
    endfunction

    // returns 0 when the beat is dropped by the block
    function automatic bit gemv_apply_beat(input logic k, input elem_t v);
        int         rows;
        int         cols;
        gemv_elem_t e;
        rows = clamp_dim(reg_rows);
        cols = clamp_dim(reg_cols);
        if (k == mvm_pkg::KIND_VECTOR)
        begin
            if (vec_fill >= mvm_pkg::MAX_DIM)
            begin
                return 1'b0;
            end
            vec_mem[vec_fill]    = v;
            vec_loaded[vec_fill] = 1'b1;
            vec_fill++;
            return 1'b1;
        end
        if (row_pos >= rows || col_pos >= cols)
        begin
            gemv_clear_pass();
        end
        if (!reg_tmode)
        begin
            row_acc = acc_add_sat(row_acc, fixed_mul(v, vec_mem[col_pos]));
            col_pos++;
            if (col_pos >= cols)
            begin
                e.value = acc_to_elem(row_acc);
                e.index = row_pos[mvm_pkg::IDX_W-1:0];
                e.last  = (row_pos + 1 == rows);
                gemv_results_due.push_back(e);
                row_acc = '0;
                col_pos = 0;
                row_pos++;
                if (row_pos >= rows)
                begin
                    row_pos  = 0;
                    vec_fill = 0;
                end
            end
        end
        else
        begin
            col_acc[col_pos] = acc_add_sat(col_acc[col_pos], fixed_mul(v, vec_mem[row_pos]));
            col_pos++;
            if (col_pos >= cols)
            begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= rows)
                begin
                    for (int c = 0; c < cols; c++)
                    begin
                        e.value = acc_to_elem(col_acc[c]);
                        e.index = c[mvm_pkg::IDX_W-1:0];
                        e.last  = (c + 1 == cols);
                        gemv_results_due.push_back(e);
                    end
                    gemv_clear_pass();
                    vec_fill = 0;
                end
            end
        end
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- checking

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (gemv_results_due.size() == 0)
            begin
                $error("result beat with nothing due: value %0d index %0d",
                       result_value, result_index);
                mismatches++;
            end
            else
            begin
                head_elem = gemv_results_due.pop_front();
                if (result_value !== head_elem.value)
                begin
                    $error("result_value: expected %0d, got %0d", head_elem.value, result_value);
                    mismatches++;
                end
                if (result_index !== head_elem.index)
                begin
                    $error("result_index: expected %0d, got %0d", head_elem.index, result_index);
                    mismatches++;
                end
                if (last !== head_elem.last)
                begin
                    $error("last: expected %0d, got %0d", head_elem.last, last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_ready <= steady_flow || ($urandom_range(0, 99) >= 14);
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic elem_t pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6, 7: return elem_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            8:
            begin
                case ($urandom_range(0, 4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    3:       return 32'h0000_0001;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return (elem_t'($urandom_range(0, 15)) - 32'sd8) <<< 16;
        endcase
    endfunction

    function automatic logic [mvm_pkg::DIM_W-1:0] pick_dim();
        int x;
        x = $urandom_range(0, 99);
        if (x < 6)
        begin
            return '0;
        end
        if (x < 14)
        begin
            return dim_t'($urandom_range(64, 127));
        end
        return dim_t'($urandom_range(1, 5));
    endfunction

    task automatic send_beat(input logic k, input elem_t v);
        if (!steady_flow && $urandom_range(0, 99) < 14)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        do @(posedge clk); while (!in_ready);
        if (gemv_apply_beat(k, v))
        begin
            items_taken++;
        end
    endtask

    // top up the vector first if the beat would read an entry never loaded
    task automatic send_matrix_beat(input elem_t v);
        while (!vec_loaded[gemv_read_index()])
        begin
            send_beat(mvm_pkg::KIND_VECTOR, pick_value());
        end
        send_beat(mvm_pkg::KIND_MATRIX, v);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (gemv_results_due.size() != 0)
        begin
            @(posedge clk);
        end
        // matrix beats without a result may still be in the pipeline
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [mvm_pkg::DIM_W-1:0] d);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        gemv_apply_cfg(idx, d);
    endtask

    task automatic set_shape(input logic [mvm_pkg::DIM_W-1:0] rows,
                             input logic [mvm_pkg::DIM_W-1:0] cols,
                             input logic [mvm_pkg::DIM_W-1:0] tmode);
        write_cfg(mvm_pkg::CFG_NUM_ROWS, rows);
        write_cfg(mvm_pkg::CFG_NUM_COLS, cols);
        write_cfg(mvm_pkg::CFG_TRANSPOSE, tmode);
    endtask

    task automatic test_vector_overflow();
        // zero rows count as one, too many columns as the maximum
        set_shape(7'd0, 7'd127, 7'd0);
        // the last two loads find the store full and are dropped
        repeat (mvm_pkg::MAX_DIM + 2) send_beat(mvm_pkg::KIND_VECTOR, pick_value());
        repeat (64) send_matrix_beat(pick_value());
    endtask

    task automatic test_dimension_clamp();
        set_shape(7'd2, 7'd0, 7'd127);
        repeat (2) send_matrix_beat(pick_value());
        set_shape(7'd3, 7'd0, 7'd0);
        repeat (3) send_matrix_beat(pick_value());
    endtask

    task automatic test_saturation();
        elem_t mat [6] = '{32'h8000_0000, 32'h7fff_ffff,
                           32'h0000_0001, 32'hffff_ffff,
                           32'h7fff_ffff, 32'h8000_0000};
        set_shape(7'd3, 7'd2, 7'd0);
        send_beat(mvm_pkg::KIND_VECTOR, 32'h8000_0000);
        send_beat(mvm_pkg::KIND_VECTOR, 32'h7fff_ffff);
        foreach (mat[i])
        begin
            send_matrix_beat(mat[i]);
        end
    endtask

    task automatic test_transpose_small();
        set_shape(7'd2, 7'd3, 7'd1);
        send_beat(mvm_pkg::KIND_VECTOR, 32'hffff_0000);
        send_beat(mvm_pkg::KIND_VECTOR, 32'h0001_8000);
        repeat (6) send_matrix_beat(pick_value());
    endtask

    task automatic test_load_during_pass();
        set_shape(7'd2, 7'd2, 7'd0);
        // old vector reused, entry 0 replaced after the first beat
        send_matrix_beat(32'h0002_0000);
        send_beat(mvm_pkg::KIND_VECTOR, 32'hfffd_0000);
        repeat (3) send_matrix_beat(pick_value());
    endtask

    task automatic test_config_abort();
        set_shape(7'd2, 7'd2, 7'd1);
        repeat (3) send_matrix_beat(pick_value());
        write_cfg(CFG_UNUSED, dim_t'($urandom_range(0, 127)));
        send_matrix_beat(pick_value());
        repeat (2) send_matrix_beat(pick_value());
        write_cfg(mvm_pkg::CFG_NUM_ROWS, 7'd2);
        repeat (4) send_matrix_beat(pick_value());
    endtask

    task automatic run_random_passes(input int item_goal, input int result_goal);
        int                         item_start;
        int                         result_start;
        int                         rows;
        int                         cols;
        int                         done;
        int                         remaining;
        logic [mvm_pkg::DIM_W-1:0]  r;
        logic [mvm_pkg::DIM_W-1:0]  c;
        item_start   = items_taken;
        result_start = results_seen;
        while (items_taken - item_start < item_goal || results_seen - result_start < result_goal)
        begin
            if ($urandom_range(0, 99) < 30)
            begin
                r = pick_dim();
                c = pick_dim();
                while (clamp_dim(r) * clamp_dim(c) > 16)
                begin
                    r = dim_t'($urandom_range(0, 4));
                    c = dim_t'($urandom_range(0, 4));
                end
                set_shape(r, c, dim_t'($urandom_range(0, 127)));
            end
            rows = clamp_dim(reg_rows);
            cols = clamp_dim(reg_cols);
            if ($urandom_range(0, 99) < 85)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    repeat (reg_tmode ? rows : cols) send_beat(mvm_pkg::KIND_VECTOR, pick_value());
                end
                done = (row_pos >= rows || col_pos >= cols) ? 0 : row_pos * cols + col_pos;
                remaining = rows * cols - done;
                // now and then leave the pass unfinished
                if ($urandom_range(0, 99) < 10)
                begin
                    remaining = $urandom_range(1, remaining);
                end
                repeat (remaining)
                begin
                    if ($urandom_range(0, 99) < 6)
                    begin
                        send_beat(mvm_pkg::KIND_VECTOR, pick_value());
                    end
                    send_matrix_beat(pick_value());
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 1))
                    begin
                        send_beat(mvm_pkg::KIND_VECTOR, pick_value());
                    end
                    else
                    begin
                        send_matrix_beat(pick_value());
                    end
                end
            end
            if ($urandom_range(0, 99) < 8)
            begin
                wait_results_drained();
            end
        end
    endtask

    task automatic test_random_no_idle();
        steady_flow = 1'b1;
        run_random_passes(8, 0);
        wait_results_drained();
        steady_flow = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_random_passes(12, 4);
    endtask

    initial
    begin
        foreach (col_acc[i])
        begin
            col_acc[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_vector_overflow();
        test_dimension_clamp();
        test_saturation();
        test_transpose_small();
        test_load_during_pass();
        test_config_abort();
        test_random_no_idle();
        test_random_traffic();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && gemv_results_due.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/mvm_pkg.sv
rtl/core/mvm_ram.sv
rtl/core/matrix_vector_multiply_unit.sv
tb/tb_matrix_vector_multiply_unit.sv
